>>> hdl/obp_pkg.sv
// shared types and constants of the optimal block partition block
package obp_pkg;

  // field widths fixed by the item formats
  localparam int unsigned POS_W   = 6;
  localparam int unsigned WIDTH_W = 6;
  localparam int unsigned COST_W  = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MASK_W  = 64;

  // payload rounding unit for word-aligned blocks
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned WORD_SHIFT = 5;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_COST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_ALIGNED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_RUN_EN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEN_MASK  = 3'd4;

  // one input item: an element width
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic               last_element;
  } elem_t;

  // one result item: a partition boundary
  typedef struct packed {
    logic [POS_W-1:0] boundary;
    logic             last_boundary;
    logic             unreachable;
  } bnd_t;

endpackage

>>> hdl/obp_ram.sv
// generic single-port-write, registered-read ram
module obp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/optimal_block_partition_top.sv
// optimal block partition: forward cost search over stored widths, then path trace
//
// channel | direction | handshake            | item
// elem    | in        | elem_valid/elem_stall | elem_t: width, last_element
// bnd     | out       | bnd_valid/bnd_stall   | bnd_t: boundary, last_boundary, unreachable
// cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// an element holds elem_stall high after its accept until the scan over its candidate block
// lengths, at most MAX_BLOCK of them, is done: one stored cost and
// width are read per cycle from the cost and width rams, through a two-stage pipe.
// a last element then traces the path through the predecessor ram into the path ram,
// then reads it back as boundary items, each loaded while the output register is free.
// reset (rst, synchronous) clears control state and the config and output registers; rams need no clearing.
// elem_stall is high while an item is in work; bnd_stall holds the output register.
module optimal_block_partition_top
  import obp_pkg::*;
#(
  parameter int unsigned MAX_SEQUENCE = 63,
  parameter int unsigned MAX_BLOCK = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 elem_valid,
  output logic                 elem_stall,
  input  elem_t                elem_data,
  output logic                 bnd_valid,
  input  logic                 bnd_stall,
  output bnd_t                 bnd_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASK_W-1:0]    cfg_data
);

  localparam int unsigned WID_AW = (MAX_SEQUENCE > 1) ? $clog2(MAX_SEQUENCE) : 1;
  localparam int unsigned POS_AW = $clog2(MAX_SEQUENCE + 1);
  localparam int unsigned CNT_W  = POS_W + 1;
  localparam int unsigned PAY_W  = 2 * WIDTH_W;
  localparam int unsigned SUM_W  = COST_W + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_TRC_WR  = 3'd2;
  localparam logic [2:0] S_TRC_RD  = 3'd3;
  localparam logic [2:0] S_EMIT_RD = 3'd4;
  localparam logic [2:0] S_EMIT_LD = 3'd5;

  // configuration registers
  logic [15:0]       fixed_cost;
  logic              word_aligned;
  logic [MASK_W-1:0] block_len_mask;
  logic              zero_run_enable;
  logic [MASK_W-1:0] zero_len_mask;

  // control state
  logic [2:0]       state;
  logic [POS_W-1:0] pos_cnt;
  logic             unreach_flag;
  logic             last_reach;
  logic             last_flag;

  // scan issue and pipeline
  logic             iss_on;
  logic [POS_W-1:0] iss_len;
  logic [POS_W-1:0] scan_lim;
  logic [POS_W-1:0] rd_j;
  logic             s1_v;
  logic [POS_W-1:0] s1_len;
  logic [POS_W-1:0] s1_j;
  logic [WIDTH_W-1:0] maxw;
  logic [WIDTH_W-1:0] maxw_n;
  logic             s1_reach;
  logic [COST_W-1:0] s1_cost;
  logic [MASK_W-1:0] s1_mask;
  logic             s2_v;
  logic             s2_ok;
  logic [POS_W-1:0] s2_len;
  logic [POS_W-1:0] s2_j;
  logic [WIDTH_W-1:0] s2_maxw;
  logic [COST_W-1:0] s2_cost;
  logic [PAY_W-1:0] pay_raw;
  logic [PAY_W-1:0] pay;
  logic [SUM_W-1:0] sum;
  logic [COST_W-1:0] cand;
  logic             found;
  logic [COST_W-1:0] best;
  logic [POS_W-1:0] pred;
  logic             scan_done;

  // trace and emit
  logic [POS_W-1:0] tpos;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] eidx;

  // ram ports
  logic [WIDTH_W-1:0] wid_rdata;
  logic [COST_W:0]    cost_rdata;
  logic [POS_W-1:0]   pred_rdata;
  logic [POS_W-1:0]   path_rdata;
  logic               elem_acc;
  logic               out_free;

  assign elem_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign elem_acc   = elem_valid && !elem_stall;
  assign out_free   = !bnd_valid || !bnd_stall;

  // scan limits and read address
  assign scan_lim  = ({1'b0, pos_cnt} < CNT_W'(MAX_BLOCK)) ? pos_cnt : POS_W'(MAX_BLOCK);
  assign rd_j      = pos_cnt - iss_len;
  assign scan_done = (state == S_SCAN) && !iss_on && !s1_v && !s2_v;

  // stage one: running maximum and length mask
  assign maxw_n   = (wid_rdata > maxw) ? wid_rdata : maxw;
  assign s1_reach = (s1_j == '0) ? 1'b1 : cost_rdata[COST_W];
  assign s1_cost  = (s1_j == '0) ? '0 : cost_rdata[COST_W-1:0];
  assign s1_mask  = (zero_run_enable && maxw_n == '0) ? zero_len_mask : block_len_mask;

  // stage two: block cost
  assign pay_raw = PAY_W'(s2_len) * PAY_W'(s2_maxw);
  assign pay     = word_aligned ? PAY_W'((pay_raw + PAY_W'(WORD_BITS - 1)) >> WORD_SHIFT)
                                : pay_raw;
  assign sum     = SUM_W'(s2_cost) + SUM_W'(pay) + SUM_W'(fixed_cost);
  assign cand    = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_cost      <= '0;
      word_aligned    <= 1'b0;
      block_len_mask  <= MASK_W'(16'hFFFF);
      zero_run_enable <= 1'b0;
      zero_len_mask   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIXED_COST:     fixed_cost      <= cfg_data[15:0];
        REG_WORD_ALIGNED:   word_aligned    <= cfg_data[0];
        REG_BLOCK_LEN_MASK: block_len_mask  <= cfg_data;
        REG_ZERO_RUN_EN:    zero_run_enable <= cfg_data[0];
        REG_ZERO_LEN_MASK:  zero_len_mask   <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan pipeline payload
  always_ff @(posedge clk) begin
    s1_len  <= iss_len;
    s1_j    <= rd_j;
    s2_ok   <= s1_mask[s1_len - POS_W'(1)] && s1_reach;
    s2_len  <= s1_len;
    s2_j    <= s1_j;
    s2_maxw <= maxw_n;
    s2_cost <= s1_cost;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos_cnt      <= '0;
      unreach_flag <= 1'b0;
      last_reach   <= 1'b0;
      last_flag    <= 1'b0;
      iss_on       <= 1'b0;
      iss_len      <= '0;
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      maxw         <= '0;
      found        <= 1'b0;
      best         <= '0;
      pred         <= '0;
      tpos         <= '0;
      cnt          <= '0;
      eidx         <= '0;
      bnd_valid    <= 1'b0;
      bnd_data     <= '0;
    end else begin
      // a taken item leaves unless the next one is loaded at the same edge
      if (bnd_valid && !bnd_stall && !((state == S_EMIT_LD) && out_free)) begin
        bnd_valid <= 1'b0;
      end
      s1_v <= (state == S_SCAN) && iss_on;
      s2_v <= s1_v;
      if (s1_v) begin
        maxw <= maxw_n;
      end
      // keep the cheapest predecessor, the longer block on equal cost
      if (s2_v && s2_ok && (!found || cand <= best)) begin
        found <= 1'b1;
        best  <= cand;
        pred  <= s2_j;
      end
      unique case (state)
        S_IDLE: begin
          if (elem_acc) begin
            last_flag <= elem_data.last_element;
            tpos      <= pos_cnt;
            cnt       <= '0;
            if (pos_cnt < POS_W'(MAX_SEQUENCE)) begin
              pos_cnt <= pos_cnt + POS_W'(1);
              iss_on  <= 1'b1;
              iss_len <= POS_W'(1);
              maxw    <= '0;
              found   <= 1'b0;
              pred    <= '0;
              state   <= S_SCAN;
            end else if (elem_data.last_element) begin
              state <= S_TRC_WR;
            end
          end
        end
        S_SCAN: begin
          if (iss_on) begin
            if (iss_len == scan_lim) begin
              iss_on <= 1'b0;
            end else begin
              iss_len <= iss_len + POS_W'(1);
            end
          end
          if (scan_done) begin
            last_reach <= found;
            if (!found) begin
              unreach_flag <= 1'b1;
            end
            tpos  <= pos_cnt;
            cnt   <= '0;
            state <= last_flag ? S_TRC_WR : S_IDLE;
          end
        end
        S_TRC_WR: begin
          cnt <= cnt + CNT_W'(1);
          if (tpos == '0) begin
            eidx  <= cnt[POS_W-1:0];
            state <= S_EMIT_RD;
          end else if (!last_reach || (cnt + CNT_W'(1) == CNT_W'(MAX_SEQUENCE))) begin
            tpos <= '0;
          end else begin
            state <= S_TRC_RD;
          end
        end
        S_TRC_RD: begin
          tpos  <= pred_rdata;
          state <= S_TRC_WR;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            bnd_valid              <= 1'b1;
            bnd_data.boundary      <= path_rdata;
            bnd_data.last_boundary <= (eidx == '0);
            bnd_data.unreachable   <= unreach_flag;
            if (eidx == '0) begin
              pos_cnt      <= '0;
              unreach_flag <= 1'b0;
              state        <= S_IDLE;
            end else begin
              eidx  <= eidx - POS_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // element widths
  obp_ram #(.WIDTH(WIDTH_W), .DEPTH(MAX_SEQUENCE), .ADDR_W(WID_AW)) u_wid_ram (
    .clk   (clk),
    .we    (elem_acc && (pos_cnt < POS_W'(MAX_SEQUENCE))),
    .waddr (pos_cnt[WID_AW-1:0]),
    .wdata (elem_data.width),
    .raddr (rd_j[WID_AW-1:0]),
    .rdata (wid_rdata)
  );

  // reach bit and best cost per position
  obp_ram #(.WIDTH(COST_W + 1), .DEPTH(MAX_SEQUENCE + 1), .ADDR_W(POS_AW)) u_cost_ram (
    .clk   (clk),
    .we    (scan_done),
    .waddr (pos_cnt[POS_AW-1:0]),
    .wdata ({found, found ? best : COST_W'(0)}),
    .raddr (rd_j[POS_AW-1:0]),
    .rdata (cost_rdata)
  );

  // best predecessor per position
  obp_ram #(.WIDTH(POS_W), .DEPTH(MAX_SEQUENCE + 1), .ADDR_W(POS_AW)) u_pred_ram (
    .clk   (clk),
    .we    (scan_done),
    .waddr (pos_cnt[POS_AW-1:0]),
    .wdata (pred),
    .raddr (tpos[POS_AW-1:0]),
    .rdata (pred_rdata)
  );

  // traced path, read back in reverse
  obp_ram #(.WIDTH(POS_W), .DEPTH(MAX_SEQUENCE + 1), .ADDR_W(POS_AW)) u_path_ram (
    .clk   (clk),
    .we    (state == S_TRC_WR),
    .waddr (cnt[POS_AW-1:0]),
    .wdata (tpos),
    .raddr (eidx[POS_AW-1:0]),
    .rdata (path_rdata)
  );

  // a boundary item appears only after a path read
  a_bnd_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(bnd_valid) |-> $past(state) == S_EMIT_LD)
    else $error("boundary item outside emit");

  // stored sequence never exceeds its depth
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos_cnt <= POS_W'(MAX_SEQUENCE))
    else $error("position count overflow");

  // a chosen predecessor lies before the solved position
  a_pred_before: assert property (@(posedge clk) disable iff (rst)
    (scan_done && found) |-> pred < pos_cnt)
    else $error("predecessor not before position");

  // the pipe is empty whenever a new element is taken
  a_pipe_idle: assert property (@(posedge clk) disable iff (rst)
    elem_acc |-> !s1_v && !s2_v && !iss_on)
    else $error("scan pipe busy on accept");

endmodule
